>>> hdl/rdl_pkg.sv
// Shared types and codes for the replay deduplication ledger.
`default_nettype none
package rdl_pkg;

	localparam logic [1:0] REQ_FIND   = 2'd0;
	localparam logic [1:0] REQ_RECORD = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_NOT_FOUND = 3'd0,
		ST_CONFLICT  = 3'd1,
		ST_REPLAY    = 3'd2,
		ST_INSERTED  = 3'd3,
		ST_SAME      = 3'd4,
		ST_REJECTED  = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] request_id;
		logic [7:0]  request_action;
		logic [31:0] target_instance;
		logic [31:0] expected_revision;
		logic        request_valid;
		logic [31:0] result_request_id;
		logic [7:0]  result_action;
		logic [7:0]  result_code;
		logic [31:0] result_revision;
		logic [15:0] result_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  stored_code;
		logic [31:0] stored_revision;
		logic [15:0] stored_tag;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_EVICT,
		S_INSERT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    scan_init;
		logic    issue;
		logic    evict;
		logic    insert;
		logic    clear_ledger;
		logic    emit;
		status_t emit_status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       pre_ok;
		logic       live_zero;
		logic       hit;
		logic       scan_end;
		logic       match_req;
		logic       match_res;
	} ctrl_sts_t;

endpackage
`default_nettype wire

>>> hdl/rdl_ctrl.sv
// Controller state machine that sequences decode, ledger scan, eviction and insert.
`default_nettype none
module rdl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output rdl_pkg::ctrl_cmd_t     cmd,
	input  wire rdl_pkg::ctrl_sts_t sts
);

	rdl_pkg::state_t state_q;
	rdl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.emit_status = rdl_pkg::ST_REJECTED;
		busy            = 1'b1;
		case (state_q)
			rdl_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = rdl_pkg::S_DECODE;
				end
			end
			rdl_pkg::S_DECODE: begin
				case (sts.req_type)
					rdl_pkg::REQ_FIND: begin
						if (sts.live_zero) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = rdl_pkg::ST_NOT_FOUND;
							state_d         = rdl_pkg::S_IDLE;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = rdl_pkg::S_SCAN;
						end
					end
					rdl_pkg::REQ_RECORD: begin
						if (!sts.pre_ok) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = rdl_pkg::ST_REJECTED;
							state_d         = rdl_pkg::S_IDLE;
						end else if (sts.live_zero) begin
							state_d = rdl_pkg::S_EVICT;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = rdl_pkg::S_SCAN;
						end
					end
					rdl_pkg::REQ_CLEAR: begin
						cmd.clear_ledger = 1'b1;
						cmd.emit         = 1'b1;
						cmd.emit_status  = rdl_pkg::ST_CLEARED;
						state_d          = rdl_pkg::S_IDLE;
					end
					default: begin
						cmd.emit        = 1'b1;
						cmd.emit_status = rdl_pkg::ST_REJECTED;
						state_d         = rdl_pkg::S_IDLE;
					end
				endcase
			end
			rdl_pkg::S_SCAN: begin
				cmd.issue = !sts.hit && !sts.scan_end;
				if (sts.hit) begin
					cmd.emit = 1'b1;
					state_d  = rdl_pkg::S_IDLE;
					if (sts.req_type == rdl_pkg::REQ_FIND) begin
						cmd.emit_status = sts.match_req ? rdl_pkg::ST_REPLAY
						                                : rdl_pkg::ST_CONFLICT;
					end else begin
						cmd.emit_status = (sts.match_req && sts.match_res)
						                ? rdl_pkg::ST_SAME : rdl_pkg::ST_REJECTED;
					end
				end else if (sts.scan_end) begin
					if (sts.req_type == rdl_pkg::REQ_FIND) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = rdl_pkg::ST_NOT_FOUND;
						state_d         = rdl_pkg::S_IDLE;
					end else begin
						state_d = rdl_pkg::S_EVICT;
					end
				end
			end
			rdl_pkg::S_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = rdl_pkg::S_INSERT;
			end
			rdl_pkg::S_INSERT: begin
				cmd.insert      = 1'b1;
				cmd.emit        = 1'b1;
				cmd.emit_status = rdl_pkg::ST_INSERTED;
				state_d         = rdl_pkg::S_IDLE;
			end
			default: begin
				state_d = rdl_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/rdl_dpath.sv
// Datapath with the entry ring memory, scan pointer, occupancy counters and result register.
`default_nettype none
module rdl_dpath #(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rdl_pkg::req_t      req,
	input  wire logic [4:0]         capacity,
	input  wire rdl_pkg::ctrl_cmd_t cmd,
	output rdl_pkg::ctrl_sts_t      sts,
	output rdl_pkg::res_t           res,
	output logic                    done
);

	localparam int KEY_W = (ID_WIDTH < 32) ? ID_WIDTH : 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = (CW > 5) ? CW : 5;
	localparam int SW    = ((AW > CW) ? AW : CW) + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [7:0]       action;
		logic [31:0]      target;
		logic [31:0]      expected;
		logic [7:0]       code;
		logic [31:0]      revision;
		logic [15:0]      tag;
	} entry_t;

	entry_t mem [DEPTH];
	entry_t rdata_q;
	entry_t wentry;

	rdl_pkg::req_t req_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] live_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] issue_cnt_q;
	logic          valid_s1;
	rdl_pkg::res_t res_q;
	logic          done_q;

	logic [EW-1:0] cap_e;
	logic [EW-1:0] eff_cap;
	logic          full;
	logic [SW-1:0] drop;
	logic [SW-1:0] osum;
	logic [SW-1:0] isum;
	logic [AW-1:0] oldest_evict;
	logic [AW-1:0] ins_slot;
	logic          emit_replay;

	always_comb begin
		cap_e   = EW'(capacity);
		eff_cap = cap_e;
		if (cap_e == '0) begin
			eff_cap = EW'(1);
		end
		if (cap_e > DEPTH_E) begin
			eff_cap = DEPTH_E;
		end
		full = EW'(live_q) >= eff_cap;
		drop = SW'(live_q) - SW'(eff_cap) + SW'(1);
		osum = SW'(oldest_q) + drop;
		if (osum >= DEPTH_S) begin
			osum = osum - DEPTH_S;
		end
		oldest_evict = osum[AW-1:0];
		isum = SW'(oldest_q) + SW'(live_q);
		if (isum >= DEPTH_S) begin
			isum = isum - DEPTH_S;
		end
		ins_slot = isum[AW-1:0];
	end

	always_comb begin
		wentry.key      = req_q.request_id[KEY_W-1:0];
		wentry.action   = req_q.request_action;
		wentry.target   = req_q.target_instance;
		wentry.expected = req_q.expected_revision;
		wentry.code     = req_q.result_code;
		wentry.revision = req_q.result_revision;
		wentry.tag      = req_q.result_tag;
	end

	always_comb begin
		sts.req_type  = req_q.req_type;
		sts.pre_ok    = req_q.request_valid
		             && (req_q.result_request_id[KEY_W-1:0] == req_q.request_id[KEY_W-1:0])
		             && (req_q.result_action == req_q.request_action);
		sts.live_zero = live_q == '0;
		sts.hit       = valid_s1 && (rdata_q.key == req_q.request_id[KEY_W-1:0]);
		sts.scan_end  = issue_cnt_q == live_q;
		sts.match_req = (rdata_q.action == req_q.request_action)
		             && (rdata_q.target == req_q.target_instance)
		             && (rdata_q.expected == req_q.expected_revision);
		sts.match_res = (rdata_q.code == req_q.result_code)
		             && (rdata_q.revision == req_q.result_revision)
		             && (rdata_q.tag == req_q.result_tag);
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem[ins_slot] <= wentry;
		end
		if (cmd.issue) begin
			rdata_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			live_q      <= '0;
			ptr_q       <= '0;
			issue_cnt_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				ptr_q       <= oldest_q;
				issue_cnt_q <= '0;
				valid_s1    <= 1'b0;
			end else begin
				valid_s1 <= cmd.issue;
				if (cmd.issue) begin
					ptr_q       <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);
					issue_cnt_q <= issue_cnt_q + CW'(1);
				end
			end
			if (cmd.clear_ledger) begin
				oldest_q <= '0;
				live_q   <= '0;
			end else if (cmd.evict && full) begin
				oldest_q <= oldest_evict;
				live_q   <= CW'(eff_cap - EW'(1));
			end else if (cmd.insert) begin
				live_q <= live_q + CW'(1);
			end
		end
	end

	assign emit_replay = cmd.emit_status == rdl_pkg::ST_REPLAY;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.status          <= cmd.emit_status;
			res_q.stored_code     <= emit_replay ? rdata_q.code : '0;
			res_q.stored_revision <= emit_replay ? rdata_q.revision : '0;
			res_q.stored_tag      <= emit_replay ? rdata_q.tag : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule
`default_nettype wire

>>> hdl/replay_dedup_ledger.sv
// Top level of the replay deduplication ledger with its configuration register port.
//
//   Channel   Handshake            Payload
//   request   start, busy          req (rdl_pkg::req_t)
//   result    done (one cycle)     res (rdl_pkg::res_t)
//   config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A clear, a rejected record or a find on an empty ledger is answered from the decode state.
// A record into an empty ledger goes from decode through the evict and insert states.
// A find or record scans the live entries oldest first, reading one entry at a time through
// the single read port of the entry memory; a record with no hit then goes to evict and insert.
// Reset empties the ledger and sets capacity to 16; entry contents are not cleared.
// busy is high while a request is in work; done needs no acknowledge.
`default_nettype none
module replay_dedup_ledger #(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rdl_pkg::req_t req,
	output logic               done,
	output rdl_pkg::res_t      res,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	rdl_pkg::ctrl_cmd_t cmd;
	rdl_pkg::ctrl_sts_t sts;
	logic [4:0]         capacity_q;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == rdl_pkg::REG_CAPACITY;
	assign prdata  = reg_sel ? {27'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= rdl_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[4:0];
		end
	end

	rdl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	rdl_dpath #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.capacity (capacity_q),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res),
		.done     (done)
	);

endmodule
`default_nettype wire
